// File: rtl/ensc_pkg.sv
// Shared types and constants for the environmental sensor compensation core.
// Used by the serial multiplier, the serial divider and the top level.
`timescale 1ns / 1ps

package ensc_pkg;

   // Result and request beats.
   typedef struct packed {
      logic [23:0] raw_temperature;
      logic [23:0] raw_pressure;
      logic [15:0] raw_humidity;
   } ensc_req_type;

   typedef struct packed {
      logic signed [18:0] temperature_centi;
      logic               temperature_valid;
      logic signed [31:0] pressure_q24_8;
      logic               pressure_valid;
      logic        [16:0] humidity_q22_10;
      logic               humidity_valid;
   } ensc_rsp_type;

   // Request to the serial multiplier: a start pulse and the operand width.
   typedef struct packed {
      logic start;
      logic wide;
   } ensc_mul_req_type;

   // Operation width, expressed as the number of multiplier bits processed.
   localparam int unsigned CNT_W = 7;
   localparam logic [CNT_W-1:0] MUL_LEN_NARROW = 7'd32;
   localparam logic [CNT_W-1:0] MUL_LEN_WIDE   = 7'd64;
   localparam logic [CNT_W-1:0] DIV_LEN        = 7'd64;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIXED      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HUM        = 3'd4;

   // Disabled-measurement codes.
   localparam logic [23:0] RAW24_OFF = 24'h800000;
   localparam logic [15:0] RAW16_OFF = 16'h8000;

   // Compensation constants.
   localparam logic [63:0] P_FINE_OFS   = 64'd128000;
   localparam logic [63:0] P_RAW_BASE   = 64'd1048576;
   localparam logic [63:0] P_SCALE      = 64'd3125;
   localparam logic [63:0] P_BIAS47     = 64'h0000_8000_0000_0000;
   localparam logic [31:0] H_FINE_OFS   = 32'd76800;
   localparam logic [31:0] H_ROUND14    = 32'd16384;
   localparam logic [31:0] H_OFS21      = 32'd2097152;
   localparam logic [31:0] H_ROUND13    = 32'd8192;
   localparam logic [31:0] H_OFS15      = 32'd32768;
   localparam logic [31:0] H_MAX        = 32'd419430400;
   localparam logic [31:0] T_ROUND      = 32'd128;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_TM1, ST_TM2, ST_TM3,
      ST_PM1, ST_PM2, ST_PM3, ST_PM4, ST_PM5, ST_PM6, ST_PM7,
      ST_PDIV,
      ST_PM8, ST_PM9, ST_PM10,
      ST_PFIN,
      ST_HM1, ST_HM2, ST_HM3, ST_HM4, ST_HM5, ST_HM6, ST_HM7, ST_HM8,
      ST_DONE
   } ensc_state_type;

endpackage

// File: rtl/ensc_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Gives the low 64 bits of the product; depends on ensc_pkg.
`timescale 1ns / 1ps

module ensc_mul
   import ensc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ensc_mul_req_type req,
   input  logic [63:0]      op_a,
   input  logic [63:0]      op_b,
   output logic             done,
   output logic [63:0]      product
);

   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      a_ff, a_in;
   logic [63:0]      b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   // One multiplier bit per cycle: add the shifted multiplicand when the bit is set.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (req.start) begin
         acc_in = '0;
         a_in   = op_a;
         b_in   = op_b;
         cnt_in = req.wide ? MUL_LEN_WIDE : MUL_LEN_NARROW;
      end else if (cnt_ff != '0) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in    = {a_ff[62:0], 1'b0};
         b_in    = {1'b0, b_ff[63:1]};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

   // Completion comes only after the last bit has been consumed.
   a_mul_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (cnt_ff == '0))
      else $error("multiplier done while bits remain");

   a_mul_start_runs: assert property (@(posedge clock) disable iff (reset)
      req.start |=> (cnt_ff != '0) && !done_ff)
      else $error("multiplier did not start counting");

endmodule

// File: rtl/ensc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, signed 64-bit
// operands with the quotient truncated toward zero; depends on ensc_pkg.
`timescale 1ns / 1ps

module ensc_div
   import ensc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);

   logic [63:0]      rem_ff, rem_in;
   logic [63:0]      quo_ff, quo_in;
   logic [63:0]      den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [64:0]      rem_sh;
   logic [64:0]      rem_diff;

   // Magnitudes on start, then one restoring step per cycle.
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      rem_sh   = {rem_ff, quo_ff[63]};
      rem_diff = rem_sh - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[63] ? (64'd0 - dividend) : dividend;
         den_in = divisor[63] ? (64'd0 - divisor) : divisor;
         neg_in = dividend[63] ^ divisor[63];
         cnt_in = DIV_LEN;
      end else if (cnt_ff != '0) begin
         if (!rem_diff[64]) begin
            rem_in = rem_diff[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (64'd0 - quo_ff) : quo_ff;

endmodule

// File: rtl/env_sensor_compensation_core.sv
// Environmental sensor compensation core: one shared bit-serial multiplier and
// one bit-serial divider under a sequencer; depends on ensc_pkg, ensc_mul, ensc_div.
// With all channels enabled an item runs up to 21 multiplies and one divide on the
// serial units between start and rsp_strobe.
// One item at a time; the next start is taken in the cycle the result is strobed.
// Synchronous reset clears the coefficients, the fine temperature and the sequencer.
`timescale 1ns / 1ps

module env_sensor_compensation_core
   import ensc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ensc_req_type         req_data,
   output logic                 rsp_strobe,
   output ensc_rsp_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] sx8(input logic [7:0] v);
      return {{56{v[7]}}, v};
   endfunction

   function automatic logic [31:0] sra32(input logic [31:0] v, input logic [5:0] n);
      return 32'($signed(v) >>> n);
   endfunction

   function automatic logic [63:0] sra64(input logic [63:0] v, input logic [6:0] n);
      return 64'($signed(v) >>> n);
   endfunction

   function automatic logic [18:0] sat19(input logic [31:0] v);
      logic [18:0] r;
      if ($signed(v) > 32'sd262143) begin
         r = 19'h3FFFF;
      end else if ($signed(v) < -32'sd262144) begin
         r = 19'h40000;
      end else begin
         r = v[18:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic [63:0] v);
      logic [31:0] r;
      if ($signed(v) > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if ($signed(v) < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Coefficient registers.
   logic [47:0] temp_ff;
   logic [63:0] press_lo_ff;
   logic [63:0] press_hi_ff;
   logic [47:0] mixed_ff;
   logic [31:0] hum_ff;

   // Sequencer and working registers.
   ensc_state_type st_ff, st_in;
   logic           issued_ff, issued_in;
   ensc_req_type   req_ff, req_in;
   logic           tv_ff, tv_in, pv_ff, pv_in, hv_ff, hv_in;
   logic [31:0]    fine_ff, fine_in;
   logic [63:0]    wa_ff, wa_in, wb_ff, wb_in, wc_ff, wc_in, wd_ff, wd_in;
   logic [31:0]    pres_ff, pres_in;
   logic [16:0]    hres_ff, hres_in;
   ensc_rsp_type   rsp_ff, rsp_in;
   logic           rsp_strobe_ff, rsp_strobe_in;

   // Shared units.
   ensc_mul_req_type mul_req;
   logic [63:0]      mul_a, mul_b, mul_prod;
   logic             mul_done;
   logic             div_start, div_done;
   logic [63:0]      div_q;
   logic             use_mul, use_div, op_cap, press_zero;

   // Coefficient fields.
   logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
   logic [7:0]  h1, h3, h6;
   logic [11:0] h4, h5;
   logic [63:0] pv1;
   logic [31:0] hx, tsum, tsh, hfin;

   assign t1 = temp_ff[15:0];
   assign t2 = temp_ff[31:16];
   assign t3 = temp_ff[47:32];
   assign p1 = press_lo_ff[15:0];
   assign p2 = press_lo_ff[31:16];
   assign p3 = press_lo_ff[47:32];
   assign p4 = press_lo_ff[63:48];
   assign p5 = press_hi_ff[15:0];
   assign p6 = press_hi_ff[31:16];
   assign p7 = press_hi_ff[47:32];
   assign p8 = press_hi_ff[63:48];
   assign p9 = mixed_ff[15:0];
   assign h1 = mixed_ff[23:16];
   assign h2 = mixed_ff[39:24];
   assign h3 = mixed_ff[47:40];
   assign h4 = hum_ff[11:0];
   assign h5 = hum_ff[23:12];
   assign h6 = hum_ff[31:24];

   // Temperature-derived offsets used by pressure and humidity, and the scaled temperature.
   assign pv1  = {{32{fine_ff[31]}}, fine_ff} - P_FINE_OFS;
   assign hx   = fine_ff - H_FINE_OFS;
   assign tsum = {fine_ff[29:0], 2'b00} + fine_ff + T_ROUND;
   assign tsh  = sra32(tsum, 6'd8);

   assign op_cap     = issued_ff && (mul_done || div_done);
   assign press_zero = (sra64(mul_prod, 7'd33) == '0);
   assign busy       = (st_ff != ST_IDLE);
   assign csr_ready  = 1'b1;

   ensc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   ensc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wa_ff),
      .divisor  (wc_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Next state.
   always_comb begin
      ensc_state_type after_t, after_p;
      after_p = hv_ff ? ST_HM1 : ST_DONE;
      after_t = pv_ff ? ST_PM1 : after_p;
      st_in   = st_ff;
      unique case (st_ff)
         ST_IDLE:     if (start) st_in = ST_DISPATCH;
         ST_DISPATCH: st_in = tv_ff ? ST_TM1 : after_t;
         ST_TM1:      if (op_cap) st_in = ST_TM2;
         ST_TM2:      if (op_cap) st_in = ST_TM3;
         ST_TM3:      if (op_cap) st_in = after_t;
         ST_PM1:      if (op_cap) st_in = ST_PM2;
         ST_PM2:      if (op_cap) st_in = ST_PM3;
         ST_PM3:      if (op_cap) st_in = ST_PM4;
         ST_PM4:      if (op_cap) st_in = ST_PM5;
         ST_PM5:      if (op_cap) st_in = ST_PM6;
         ST_PM6:      if (op_cap) st_in = press_zero ? after_p : ST_PM7;
         ST_PM7:      if (op_cap) st_in = ST_PDIV;
         ST_PDIV:     if (op_cap) st_in = ST_PM8;
         ST_PM8:      if (op_cap) st_in = ST_PM9;
         ST_PM9:      if (op_cap) st_in = ST_PM10;
         ST_PM10:     if (op_cap) st_in = ST_PFIN;
         ST_PFIN:     st_in = after_p;
         ST_HM1:      if (op_cap) st_in = ST_HM2;
         ST_HM2:      if (op_cap) st_in = ST_HM3;
         ST_HM3:      if (op_cap) st_in = ST_HM4;
         ST_HM4:      if (op_cap) st_in = ST_HM5;
         ST_HM5:      if (op_cap) st_in = ST_HM6;
         ST_HM6:      if (op_cap) st_in = ST_HM7;
         ST_HM7:      if (op_cap) st_in = ST_HM8;
         ST_HM8:      if (op_cap) st_in = ST_DONE;
         ST_DONE:     st_in = ST_IDLE;
         default:     st_in = ST_IDLE;
      endcase
   end

   // Datapath: operand selection per step and capture of each product.
   always_comb begin
      logic [63:0] psum;
      logic [31:0] hraw;
      logic [20:0] praw;
      psum          = wd_ff + wa_ff + wb_ff;
      hraw          = wa_ff[31:0] - sra32(mul_prod[31:0], 6'd4);
      praw          = P_RAW_BASE[20:0] - {1'b0, req_ff.raw_pressure[23:4]};
      use_mul       = 1'b0;
      use_div       = 1'b0;
      mul_req.wide  = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      req_in        = req_ff;
      tv_in         = tv_ff;
      pv_in         = pv_ff;
      hv_in         = hv_ff;
      fine_in       = fine_ff;
      wa_in         = wa_ff;
      wb_in         = wb_ff;
      wc_in         = wc_ff;
      wd_in         = wd_ff;
      pres_in       = pres_ff;
      hres_in       = hres_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      hfin          = hraw;
      if (hraw[31]) begin
         hfin = '0;
      end else if (hraw > H_MAX) begin
         hfin = H_MAX;
      end
      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               tv_in  = (req_data.raw_temperature != RAW24_OFF);
               pv_in  = (req_data.raw_pressure != RAW24_OFF);
               hv_in  = (req_data.raw_humidity != RAW16_OFF);
            end
         end
         ST_DISPATCH: begin
            pres_in = '0;
            hres_in = '0;
         end
         // Temperature, 32-bit wrapping.
         ST_TM1: begin
            use_mul = 1'b1;
            mul_a   = {32'd0, {15'd0, req_ff.raw_temperature[23:7]} - {15'd0, t1, 1'b0}};
            mul_b   = sx16(t2);
            if (op_cap) wa_in = {32'd0, sra32(mul_prod[31:0], 6'd11)};
         end
         ST_TM2: begin
            use_mul = 1'b1;
            mul_a   = {32'd0, {16'd0, req_ff.raw_temperature[23:8]} - {16'd0, t1}};
            mul_b   = mul_a;
            if (op_cap) wb_in = {32'd0, sra32(mul_prod[31:0], 6'd12)};
         end
         ST_TM3: begin
            use_mul = 1'b1;
            mul_a   = wb_ff;
            mul_b   = sx16(t3);
            if (op_cap) fine_in = wa_ff[31:0] + sra32(mul_prod[31:0], 6'd14);
         end
         // Pressure, 64-bit wrapping.
         ST_PM1: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = pv1;
            mul_b        = pv1;
            if (op_cap) wa_in = mul_prod;
         end
         ST_PM2: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = wa_ff;
            mul_b        = sx16(p6);
            if (op_cap) wb_in = mul_prod;
         end
         ST_PM3: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = pv1;
            mul_b        = sx16(p5);
            if (op_cap) begin
               wb_in = wb_ff + {mul_prod[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
            end
         end
         ST_PM4: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = wa_ff;
            mul_b        = sx16(p3);
            if (op_cap) wc_in = sra64(mul_prod, 7'd8);
         end
         ST_PM5: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = pv1;
            mul_b        = sx16(p2);
            if (op_cap) wc_in = wc_ff + {mul_prod[51:0], 12'd0};
         end
         ST_PM6: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = P_BIAS47 + wc_ff;
            mul_b        = {48'd0, p1};
            if (op_cap) wc_in = sra64(mul_prod, 7'd33);
         end
         ST_PM7: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = {12'd0, praw, 31'd0} - wb_ff;
            mul_b        = P_SCALE;
            if (op_cap) wa_in = mul_prod;
         end
         ST_PDIV: begin
            use_div = 1'b1;
            if (op_cap) wd_in = div_q;
         end
         ST_PM8: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = sx16(p9);
            mul_b        = sra64(wd_ff, 7'd13);
            if (op_cap) wa_in = mul_prod;
         end
         ST_PM9: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = wa_ff;
            mul_b        = sra64(wd_ff, 7'd13);
            if (op_cap) wa_in = sra64(mul_prod, 7'd25);
         end
         ST_PM10: begin
            use_mul      = 1'b1;
            mul_req.wide = 1'b1;
            mul_a        = sx16(p8);
            mul_b        = wd_ff;
            if (op_cap) wb_in = sra64(mul_prod, 7'd19);
         end
         ST_PFIN: begin
            pres_in = sat32(sra64(psum, 7'd8) + {{44{p7[15]}}, p7, 4'd0});
         end
         // Humidity, 32-bit wrapping.
         ST_HM1: begin
            use_mul = 1'b1;
            mul_a   = {52'd0, h5};
            mul_b   = {32'd0, hx};
            if (op_cap) begin
               wa_in = {32'd0, sra32({2'd0, req_ff.raw_humidity, 14'd0} - {h4, 20'd0}
                                     - mul_prod[31:0] + H_ROUND14, 6'd15)};
            end
         end
         ST_HM2: begin
            use_mul = 1'b1;
            mul_a   = {32'd0, hx};
            mul_b   = sx8(h6);
            if (op_cap) wb_in = {32'd0, sra32(mul_prod[31:0], 6'd10)};
         end
         ST_HM3: begin
            use_mul = 1'b1;
            mul_a   = {32'd0, hx};
            mul_b   = {56'd0, h3};
            if (op_cap) wc_in = {32'd0, sra32(mul_prod[31:0], 6'd11) + H_OFS15};
         end
         ST_HM4: begin
            use_mul = 1'b1;
            mul_a   = wb_ff;
            mul_b   = wc_ff;
            if (op_cap) wb_in = {32'd0, sra32(mul_prod[31:0], 6'd10) + H_OFS21};
         end
         ST_HM5: begin
            use_mul = 1'b1;
            mul_a   = wb_ff;
            mul_b   = sx16(h2);
            if (op_cap) wb_in = {32'd0, sra32(mul_prod[31:0] + H_ROUND13, 6'd14)};
         end
         ST_HM6: begin
            use_mul = 1'b1;
            mul_a   = wa_ff;
            mul_b   = wb_ff;
            if (op_cap) wa_in = {32'd0, mul_prod[31:0]};
         end
         ST_HM7: begin
            use_mul = 1'b1;
            mul_a   = {32'd0, sra32(wa_ff[31:0], 6'd15)};
            mul_b   = mul_a;
            if (op_cap) wc_in = {32'd0, sra32(mul_prod[31:0], 6'd7)};
         end
         ST_HM8: begin
            use_mul = 1'b1;
            mul_a   = wc_ff;
            mul_b   = {56'd0, h1};
            if (op_cap) hres_in = hfin[28:12];
         end
         ST_DONE: begin
            rsp_in.temperature_centi = tv_ff ? sat19(tsh) : '0;
            rsp_in.temperature_valid = tv_ff;
            rsp_in.pressure_q24_8    = pres_ff;
            rsp_in.pressure_valid    = pv_ff;
            rsp_in.humidity_q22_10   = hres_ff;
            rsp_in.humidity_valid    = hv_ff;
            rsp_strobe_in            = 1'b1;
         end
         default: begin
         end
      endcase
      mul_req.start = use_mul && !issued_ff;
      div_start     = use_div && !issued_ff;
      issued_in     = (use_mul || use_div) && !op_cap;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         issued_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         fine_ff       <= '0;
         temp_ff       <= '0;
         press_lo_ff   <= '0;
         press_hi_ff   <= '0;
         mixed_ff      <= '0;
         hum_ff        <= '0;
      end else begin
         st_ff         <= st_in;
         issued_ff     <= issued_in;
         rsp_strobe_ff <= rsp_strobe_in;
         fine_ff       <= fine_in;
         // Configuration beat; unknown indexes are dropped.
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TEMP:       temp_ff     <= csr_wdata[47:0];
               CSR_PRESS_LOW:  press_lo_ff <= csr_wdata;
               CSR_PRESS_HIGH: press_hi_ff <= csr_wdata;
               CSR_MIXED:      mixed_ff    <= csr_wdata[47:0];
               CSR_HUM:        hum_ff      <= csr_wdata[31:0];
               default: begin
               end
            endcase
         end
      end
      req_ff  <= req_in;
      tv_ff   <= tv_in;
      pv_ff   <= pv_in;
      hv_ff   <= hv_in;
      wa_ff   <= wa_in;
      wb_ff   <= wb_in;
      wc_ff   <= wc_in;
      wd_ff   <= wd_in;
      pres_ff <= pres_in;
      hres_ff <= hres_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // A result beat marks the end of an item: the sequencer is back to idle.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobed while still busy");

   // Every accepted item ends in exactly one result beat when busy drops.
   a_fall_strobe: assert property (@(posedge clock) disable iff (reset)
      (busy && st_ff == ST_DONE) |=> rsp_strobe && !busy)
      else $error("busy dropped without a result beat");

   // Units only finish when the sequencer launched them.
   a_unit_owned: assert property (@(posedge clock) disable iff (reset)
      (mul_done || div_done) |-> issued_ff && !(mul_done && div_done))
      else $error("unexpected completion from a serial unit");

   // The fine temperature only changes on the final temperature step.
   a_fine_write: assert property (@(posedge clock) disable iff (reset)
      (fine_ff != $past(fine_ff)) |-> ($past(st_ff) == ST_TM3))
      else $error("fine temperature changed outside its update step");

endmodule

// File: tb/tb_env_sensor_compensation_core.sv
// Self-checking testbench for env_sensor_compensation_core: checks every result beat
// against a predictor of the integer compensation formulas. Depends on ensc_pkg.
`timescale 1ns / 1ps

module tb_env_sensor_compensation_core;
   import ensc_pkg::*;

   localparam int unsigned RESET_CYCLES = 10;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned TAIL_CYCLES = 1500;
   localparam longint unsigned CYCLE_LIMIT = 10_000_000;

   typedef enum logic [1:0] {OP_SAMPLE, OP_WRITE, OP_SYNC} op_kind_type;

   typedef struct {
      op_kind_type            kind;
      ensc_req_type           sample;
      logic [CSR_IDX_W-1:0]   index;
      logic [63:0]            wdata;
      bit                     calm;
   } op_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   ensc_req_type         req_data = '0;
   logic                 rsp_strobe;
   ensc_rsp_type         rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_wdata = '0;

   op_type       op_q[$];
   ensc_rsp_type comp_expected_q[$];

   // Shadow copy of the coefficient registers and the fine temperature.
   logic [63:0] cal_temp, cal_press_lo, cal_press_hi, cal_mixed, cal_hum;
   logic [31:0] fine_t;

   int unsigned     error_count = 0;
   int unsigned     samples_sent = 0;
   int unsigned     writes_done = 0;
   int unsigned     results_checked = 0;
   longint unsigned cycle_count = 0;

   always #1 clock = ~clock;

   env_sensor_compensation_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Arithmetic shifts and sign extension at the block's widths.
   function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
      logic signed [31:0] s;
      s = v;
      return s >>> n;
   endfunction

   function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
      logic signed [63:0] s;
      s = v;
      return s >>> n;
   endfunction

   function automatic logic [63:0] sext16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   // Signed 64-bit divide truncating toward zero, done on magnitudes so that
   // the most negative dividend wraps the same way as in the hardware.
   function automatic logic [63:0] quot64(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ma, mb, q;
      ma = a[63] ? 64'(0 - a) : a;
      mb = b[63] ? 64'(0 - b) : b;
      q = ma / mb;
      return (a[63] != b[63]) ? 64'(0 - q) : q;
   endfunction

   // Temperature: updates the fine temperature, returns hundredths of a degree.
   function automatic logic [18:0] temp_centi(input logic [23:0] raw);
      logic [31:0] a, t1, t2, t3, v1, d, v2, t;
      logic signed [31:0] st;
      a = {8'd0, raw} >> 4;
      t1 = {16'd0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      v1 = sra32(32'(((a >> 3) - (t1 << 1)) * t2), 11);
      d = (a >> 4) - t1;
      v2 = sra32(32'(sra32(32'(d * d), 12) * t3), 14);
      fine_t = v1 + v2;
      t = sra32(32'(fine_t * 32'd5 + T_ROUND), 8);
      st = t;
      if (st < -32'sd262144) st = -32'sd262144;
      if (st > 32'sd262143) st = 32'sd262143;
      return st[18:0];
   endfunction

   // Pressure in Q24.8 pascals, zero when the divisor is zero, saturated to 32 bits.
   function automatic logic [31:0] press_q24_8(input logic [23:0] raw);
      logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, v1, v2, p, q;
      logic signed [63:0] sp;
      p1 = {48'd0, cal_press_lo[15:0]};
      p2 = sext16(cal_press_lo[31:16]);
      p3 = sext16(cal_press_lo[47:32]);
      p4 = sext16(cal_press_lo[63:48]);
      p5 = sext16(cal_press_hi[15:0]);
      p6 = sext16(cal_press_hi[31:16]);
      p7 = sext16(cal_press_hi[47:32]);
      p8 = sext16(cal_press_hi[63:48]);
      p9 = sext16(cal_mixed[15:0]);
      a = {40'd0, raw} >> 4;
      v1 = {{32{fine_t[31]}}, fine_t} - P_FINE_OFS;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) << 17);
      v2 = v2 + (p4 << 35);
      v1 = sra64(64'(v1 * v1 * p3), 8) + ((v1 * p2) << 12);
      v1 = sra64(64'((P_BIAS47 + v1) * p1), 33);
      if (v1 == 64'd0) return 32'd0;
      p = P_RAW_BASE - a;
      p = quot64(64'(((p << 31) - v2) * P_SCALE), v1);
      q = sra64(p, 13);
      v1 = sra64(64'(p9 * q * q), 25);
      v2 = sra64(64'(p8 * p), 19);
      p = sra64(64'(p + v1 + v2), 8) + (p7 << 4);
      sp = p;
      if (sp < -64'sd2147483648) sp = -64'sd2147483648;
      if (sp > 64'sd2147483647) sp = 64'sd2147483647;
      return sp[31:0];
   endfunction

   // Humidity in Q22.10 percent, accumulator clamped before the final shift.
   function automatic logic [16:0] hum_q22_10(input logic [15:0] raw);
      logic [31:0] h1, h2, h3, h4, h5, h6, x, l, r, s;
      h1 = {24'd0, cal_mixed[23:16]};
      h2 = {{16{cal_mixed[39]}}, cal_mixed[39:24]};
      h3 = {24'd0, cal_mixed[47:40]};
      h4 = {20'd0, cal_hum[11:0]};
      h5 = {20'd0, cal_hum[23:12]};
      h6 = {{24{cal_hum[31]}}, cal_hum[31:24]};
      x = fine_t - H_FINE_OFS;
      l = sra32(32'(({16'd0, raw} << 14) - (h4 << 20) - h5 * x + H_ROUND14), 15);
      r = 32'(sra32(32'(x * h6), 10) * (sra32(32'(x * h3), 11) + H_OFS15));
      r = sra32(32'((sra32(r, 10) + H_OFS21) * h2 + H_ROUND13), 14);
      x = l * r;
      s = sra32(x, 15);
      x = x - 32'(sra32(32'(sra32(32'(s * s), 7) * h1), 4));
      if (x[31]) x = 32'd0;
      if (x > H_MAX) x = H_MAX;
      return 17'(x >> 12);
   endfunction

   function automatic ensc_rsp_type compensate(input ensc_req_type s);
      ensc_rsp_type r;
      r = '0;
      if (s.raw_temperature != RAW24_OFF) begin
         r.temperature_centi = temp_centi(s.raw_temperature);
         r.temperature_valid = 1'b1;
      end
      if (s.raw_pressure != RAW24_OFF) begin
         r.pressure_q24_8 = press_q24_8(s.raw_pressure);
         r.pressure_valid = 1'b1;
      end
      if (s.raw_humidity != RAW16_OFF) begin
         r.humidity_q22_10 = hum_q22_10(s.raw_humidity);
         r.humidity_valid = 1'b1;
      end
      return r;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      error_count++;
      $display("MISMATCH at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
   endtask

   // Driver: launches sample and register beats from the pending queue.
   int unsigned gap_left = 0;
   int unsigned sync_count = 0;

   always @(posedge clock) begin
      logic   st, cv;
      op_type op;
      cycle_count++;
      st = start;
      cv = csr_valid;
      if (start && !busy) begin
         comp_expected_q.push_back(compensate(req_data));
         samples_sent++;
         st = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEMP:       cal_temp = csr_wdata & 64'hFFFF_FFFF_FFFF;
            CSR_PRESS_LOW:  cal_press_lo = csr_wdata;
            CSR_PRESS_HIGH: cal_press_hi = csr_wdata;
            CSR_MIXED:      cal_mixed = csr_wdata & 64'hFFFF_FFFF_FFFF;
            CSR_HUM:        cal_hum = csr_wdata & 64'hFFFF_FFFF;
            default: ;
         endcase
         writes_done++;
         cv = 1'b0;
      end
      if (!reset && !st && !cv && op_q.size() > 0) begin
         op = op_q[0];
         if (gap_left > 0) begin
            gap_left--;
         end else if (op.kind == OP_SAMPLE) begin
            void'(op_q.pop_front());
            st = 1'b1;
            req_data <= op.sample;
            if (!op.calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 7);
         end else if (op.kind == OP_WRITE) begin
            void'(op_q.pop_front());
            cv = 1'b1;
            csr_index <= op.index;
            csr_wdata <= op.wdata;
         end else if (comp_expected_q.size() != 0) begin
            sync_count = 0;
         end else if (sync_count == SETTLE_CYCLES) begin
            void'(op_q.pop_front());
            sync_count = 0;
         end else begin
            sync_count++;
         end
      end
      start <= st;
      csr_valid <= cv;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Monitor: every strobed result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      ensc_rsp_type e;
      if (!reset && rsp_strobe) begin
         if (comp_expected_q.size() == 0) begin
            error_count++;
            $display("MISMATCH at cycle %0d: result beat with none expected", cycle_count);
         end else begin
            e = comp_expected_q.pop_front();
            results_checked++;
            if (rsp_data.temperature_centi !== e.temperature_centi)
               report("temperature_centi", 64'(rsp_data.temperature_centi),
                      64'(e.temperature_centi));
            if (rsp_data.temperature_valid !== e.temperature_valid)
               report("temperature_valid", 64'(rsp_data.temperature_valid),
                      64'(e.temperature_valid));
            if (rsp_data.pressure_q24_8 !== e.pressure_q24_8)
               report("pressure_q24_8", 64'(rsp_data.pressure_q24_8), 64'(e.pressure_q24_8));
            if (rsp_data.pressure_valid !== e.pressure_valid)
               report("pressure_valid", 64'(rsp_data.pressure_valid), 64'(e.pressure_valid));
            if (rsp_data.humidity_q22_10 !== e.humidity_q22_10)
               report("humidity_q22_10", 64'(rsp_data.humidity_q22_10),
                      64'(e.humidity_q22_10));
            if (rsp_data.humidity_valid !== e.humidity_valid)
               report("humidity_valid", 64'(rsp_data.humidity_valid), 64'(e.humidity_valid));
         end
      end
   end

   // Typical calibration of a real part, used as the base of the well-formed phases.
   localparam logic [63:0] TYP_TEMP  = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_PLOW  = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_PHIGH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [63:0] TYP_MIXED = {16'd0, 8'd0, 16'd362, 8'd75, 16'd6000};
   localparam logic [63:0] TYP_HUM   = {32'd0, 8'd30, 12'd50, 12'd324};

   task automatic add_sample(input logic [23:0] t, input logic [23:0] p,
                             input logic [15:0] h, input bit calm);
      op_type op;
      op.kind = OP_SAMPLE;
      op.sample = '{raw_temperature: t, raw_pressure: p, raw_humidity: h};
      op.index = '0;
      op.wdata = '0;
      op.calm = calm;
      op_q.push_back(op);
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] v);
      op_type op;
      op.kind = OP_WRITE;
      op.sample = '0;
      op.index = idx;
      op.wdata = v;
      op.calm = 1'b0;
      op_q.push_back(op);
   endtask

   // Drain the block, then load a full calibration set and one ignored index.
   task automatic add_calibration(input logic [63:0] t, input logic [63:0] pl,
                                  input logic [63:0] ph, input logic [63:0] m,
                                  input logic [63:0] h);
      op_type op;
      op.kind = OP_SYNC;
      op.sample = '0;
      op.index = '0;
      op.wdata = '0;
      op.calm = 1'b0;
      op_q.push_back(op);
      add_write(CSR_TEMP, t);
      add_write(CSR_PRESS_LOW, pl);
      add_write(CSR_PRESS_HIGH, ph);
      add_write(CSR_MIXED, m);
      add_write(CSR_HUM, h);
      add_write(CSR_IDX_W'($urandom_range(5, 7)), {$urandom, $urandom});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Raw readings: mostly near typical values, some full range, some disabled.
   task automatic add_random_sample(input bit calm);
      logic [23:0] t, p;
      logic [15:0] h;
      if ($urandom_range(0, 2) != 0) begin
         t = 24'($urandom_range(380000, 660000));
         p = 24'($urandom_range(250000, 600000));
         h = 16'($urandom_range(15000, 45000));
      end else begin
         t = 24'($urandom);
         p = 24'($urandom);
         h = 16'($urandom);
      end
      if ($urandom_range(0, 19) == 0) t = RAW24_OFF;
      if ($urandom_range(0, 19) == 0) p = RAW24_OFF;
      if ($urandom_range(0, 19) == 0) h = RAW16_OFF;
      add_sample(t, p, h, calm);
   endtask

   localparam int unsigned PHASES = 14;
   localparam int unsigned PHASE_ITEMS = 98;

   initial begin
      logic [63:0] j;
      cal_temp = '0;
      cal_press_lo = '0;
      cal_press_hi = '0;
      cal_mixed = '0;
      cal_hum = '0;
      fine_t = '0;

      // Reset calibration: zero pressure divisor on every sample that measures pressure.
      add_sample(24'd519888, 24'd415148, 16'd30000, 1'b0);
      add_sample(24'hFFFFFF, 24'h000000, 16'hFFFF, 1'b0);
      add_sample(RAW24_OFF, RAW24_OFF, RAW16_OFF, 1'b0);

      // Typical calibration: extremes of the raw words and every disabled code.
      add_calibration(TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_MIXED, TYP_HUM);
      add_sample(24'd519888, 24'd415148, 16'd30000, 1'b0);
      add_sample(24'd0, 24'd0, 16'd0, 1'b0);
      add_sample(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b0);
      add_sample(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 1'b0);
      add_sample(24'h800001, 24'h800001, 16'h8001, 1'b0);
      add_sample(RAW24_OFF, 24'd415148, 16'd30000, 1'b0);
      add_sample(24'd600000, RAW24_OFF, 16'd30000, 1'b0);
      // A disabled temperature reuses the fine temperature of the last sample.
      add_sample(RAW24_OFF, 24'd300000, 16'd40000, 1'b0);
      add_sample(24'd519888, 24'd415148, RAW16_OFF, 1'b0);
      add_sample(24'd519888, 24'd16, 16'd65000, 1'b0);
      add_sample(24'd519888, 24'd415148, 16'd5, 1'b0);

      // Coefficient extremes: all ones, and signed minimum with unsigned zero.
      add_calibration('1, '1, '1, '1, '1);
      add_sample(24'd519888, 24'd415148, 16'd30000, 1'b0);
      add_sample(24'hFFFFFF, 24'd0, 16'hFFFF, 1'b0);
      add_sample(24'd0, 24'hFFFFFF, 16'd0, 1'b0);
      add_calibration(64'h8000_8000_0000, 64'h8000_8000_8000_0000, {4{16'h8000}},
                      64'h00_8000_00_8000, 64'h80_000_000);
      add_sample(24'd519888, 24'd415148, 16'd30000, 1'b0);
      add_sample(24'hFFFFFF, 24'd0, 16'hFFFF, 1'b0);
      add_sample(24'd0, 24'hFFFFFF, 16'd0, 1'b0);

      // Random phases, each under a new calibration; the last one runs without gaps.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 4)
            0, 1: begin
               j = rand64();
               add_calibration(TYP_TEMP ^ (j & 64'h00FF_00FF_001F),
                               TYP_PLOW ^ (rand64() & 64'h00FF_00FF_00FF_00FF),
                               TYP_PHIGH ^ (rand64() & 64'h00FF_00FF_00FF_00FF),
                               TYP_MIXED ^ (j & 64'h001F_0000_0FFF),
                               TYP_HUM ^ (rand64() & 64'h0F_0FF_0FF));
            end
            2: add_calibration(rand64(), rand64(), rand64(), rand64(), rand64());
            default: begin
               add_calibration(TYP_TEMP, TYP_PLOW & ~64'hFFFF, TYP_PHIGH,
                               TYP_MIXED, TYP_HUM);
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) add_random_sample(ph == PHASES - 1);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      wait (op_q.size() == 0 && !start && !csr_valid && comp_expected_q.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (comp_expected_q.size() != 0) begin
         error_count++;
         $display("MISMATCH: %0d results never arrived", comp_expected_q.size());
      end
      $display("Covered %0d samples and %0d register writes across %0d calibration sets;",
               samples_sent, writes_done, PHASES + 4);
      $display("%0d result beats checked, %0d mismatches.", results_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
